>>> sv/ssml_pkg.sv
package ssml_pkg;
    localparam logic [1:0] CMD_LOAD_ID    = 2'd0;
    localparam logic [1:0] CMD_LOAD_START = 2'd1;
    localparam logic [1:0] CMD_LOAD_ENTRY = 2'd2;
    localparam logic [1:0] CMD_LOOKUP     = 2'd3;
    localparam logic       REG_DOMAIN_COUNT = 1'b0;
    localparam logic       REG_ENTRY_COUNT  = 1'b1;
    localparam logic [15:0] SCORE_MISS = 16'hFFFF;
endpackage

>>> sv/ssml_ram.sv
module ssml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/sparse_symmetric_matrix_lookup.sv
// Sparse symmetric matrix lookup. Each s_axis transfer carries one command: three load
// commands write the identifier, row-start and entry tables (no result), and a lookup
// returns one m_axis transfer with found in tuser and score in tdata.
// A lookup runs sequentially through single-port-read RAMs with registered reads: each
// binary-search probe of an identifier passes through S_SRCH and S_SWAIT, fetching the
// row bounds steps through S_RS0 to S_RS3, and the row scan passes through S_SCAN and
// S_SCHK per stored entry examined. Only one item is in flight; the next is accepted
// once the result register is free. No clearing pass.
module sparse_symmetric_matrix_lookup
    import ssml_pkg::*;
#(
    parameter int MAX_DOMAINS = 1024,
    parameter int MAX_ENTRIES = 65536,
    parameter int ID_BITS     = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0], slot[17:2], domain_id[37:18], row_start[54:38], column[64:55],
    // entry_value[80:65], query_a[100:81], query_b[120:101]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // score[15:0]
    output logic [15:0]  m_axis_tdata,
    // found[0]
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [16:0]  cfg_data
);
    localparam int DA = $clog2(MAX_DOMAINS);
    localparam int EA = $clog2(MAX_ENTRIES);
    localparam int DW = DA + 1;
    localparam int EW = EA + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SWAIT, S_RS0, S_RS1, S_RS2, S_RS3, S_SCAN, S_SCHK, S_DONE
    } t_state;

    t_state r_state;
    logic [10:0] r_dom_cnt;
    logic [16:0] r_ent_cnt;
    logic [ID_BITS-1:0] r_key_lo, r_key_hi;
    logic r_second;
    logic [DW-1:0] r_lo, r_hi, r_mid, r_n, r_row, r_col;
    logic [EW-1:0] r_k, r_end;
    logic r_out_valid, r_found;
    logic [15:0] r_score;

    logic [1:0]  in_cmd;
    logic [15:0] in_slot;
    logic [19:0] in_id, qa, qb;
    logic [16:0] in_start;
    logic [9:0]  in_col;
    logic [15:0] in_val;
    assign in_cmd   = s_axis_tdata[1:0];
    assign in_slot  = s_axis_tdata[17:2];
    assign in_id    = s_axis_tdata[37:18];
    assign in_start = s_axis_tdata[54:38];
    assign in_col   = s_axis_tdata[64:55];
    assign in_val   = s_axis_tdata[80:65];
    assign qa       = s_axis_tdata[100:81];
    assign qb       = s_axis_tdata[120:101];

    logic in_fire;
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    logic [ID_BITS-1:0] ka, kb;
    assign ka = ID_BITS'(qa);
    assign kb = ID_BITS'(qb);

    // RAM ports
    logic [ID_BITS-1:0] id_rd;
    logic [16:0] rs_rd;
    logic [9:0]  col_rd;
    logic [15:0] val_rd;
    logic [DA-1:0] id_ra, rs_ra;
    logic [EA-1:0] ent_ra;
    logic id_we, rs_we, ent_we;

    assign id_we  = in_fire && in_cmd == CMD_LOAD_ID && 32'(in_slot) < MAX_DOMAINS;
    assign rs_we  = in_fire && in_cmd == CMD_LOAD_START && 32'(in_slot) < MAX_DOMAINS;
    assign ent_we = in_fire && in_cmd == CMD_LOAD_ENTRY && 32'(in_slot) < MAX_ENTRIES;

    logic [DW-1:0] mid_c;
    assign mid_c = DW'((DW+1)'(r_lo) + (DW+1)'(r_hi)) >> 1;
    assign id_ra = mid_c[DA-1:0];
    assign rs_ra = (r_state == S_RS0) ? r_row[DA-1:0] : DA'(r_row + 1'b1);
    assign ent_ra = r_k[EA-1:0];

    ssml_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_DOMAINS)) u_id (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(in_slot[DA-1:0]),
        .i_wdata(ID_BITS'(in_id)), .i_raddr(id_ra), .o_rdata(id_rd));
    ssml_ram #(.WIDTH(17), .DEPTH(MAX_DOMAINS)) u_rs (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(in_slot[DA-1:0]),
        .i_wdata(in_start), .i_raddr(rs_ra), .o_rdata(rs_rd));
    ssml_ram #(.WIDTH(10), .DEPTH(MAX_ENTRIES)) u_col (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(EA'(in_slot)),
        .i_wdata(in_col), .i_raddr(ent_ra), .o_rdata(col_rd));
    ssml_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_val (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(EA'(in_slot)),
        .i_wdata(in_val), .i_raddr(ent_ra), .o_rdata(val_rd));

    logic [ID_BITS-1:0] key;
    assign key = r_second ? r_key_hi : r_key_lo;

    function automatic logic [EW-1:0] clampe(input logic [16:0] v);
        clampe = (32'(v) > MAX_ENTRIES) ? EW'(MAX_ENTRIES) : EW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dom_cnt <= '0;
            r_ent_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_DOMAIN_COUNT) r_dom_cnt <= cfg_data[10:0];
                else r_ent_cnt <= cfg_data;
            end
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_fire && in_cmd == CMD_LOOKUP) begin
                        r_key_lo <= (ka < kb) ? ka : kb;
                        r_key_hi <= (ka < kb) ? kb : ka;
                        r_second <= 1'b0;
                        r_lo <= '0;
                        if (32'(r_dom_cnt) > MAX_DOMAINS) begin
                            r_hi <= DW'(MAX_DOMAINS); r_n <= DW'(MAX_DOMAINS);
                        end else begin
                            r_hi <= DW'(r_dom_cnt); r_n <= DW'(r_dom_cnt);
                        end
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid <= mid_c;
                        r_state <= S_SWAIT;
                    end else begin
                        r_found <= 1'b0; r_score <= SCORE_MISS; r_state <= S_DONE;
                    end
                end
                S_SWAIT: begin
                    // Hold lo/hi so the read address stays on mid for this cycle.
                    if (key < id_rd) begin
                        r_hi <= r_mid; r_state <= S_SRCH;
                    end else if (key > id_rd) begin
                        r_lo <= r_mid + 1'b1; r_state <= S_SRCH;
                    end else if (!r_second) begin
                        r_row <= r_mid; r_second <= 1'b1;
                        r_lo <= '0; r_hi <= r_n; r_state <= S_SRCH;
                    end else begin
                        r_col <= r_mid; r_state <= S_RS0;
                    end
                end
                S_RS0: r_state <= S_RS1;
                S_RS1: begin
                    r_k <= clampe(rs_rd);
                    r_state <= S_RS2;
                end
                S_RS2: r_state <= S_RS3;
                S_RS3: begin
                    r_end <= (r_row + 1'b1 != r_n) ? clampe(rs_rd) : clampe(r_ent_cnt);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_k < r_end) r_state <= S_SCHK;
                    else begin
                        r_found <= 1'b0; r_score <= SCORE_MISS; r_state <= S_DONE;
                    end
                end
                S_SCHK: begin
                    if (DW'(col_rd) == r_col) begin
                        r_found <= 1'b1; r_score <= val_rd; r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + 1'b1; r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_score;
    assign m_axis_tuser  = r_found;
endmodule

>>> sv/ssml_checker.sv
module ssml_assertions
    import ssml_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_miss_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == SCORE_MISS)
        else $error("miss without -1 score");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result dropped while stalled");
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind sparse_symmetric_matrix_lookup ssml_assertions u_ssml_assertions (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));

>>> bench/ssml_checker.sv
module ssml_checker
    import ssml_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [15:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [16:0]  cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DOMAIN_DEPTH = 1024;
    localparam int unsigned ENTRY_DEPTH  = 65536;

    typedef struct packed {
        logic        found;
        logic [15:0] score;
    } lookup_result_t;

    logic [19:0] id_tbl    [DOMAIN_DEPTH];
    logic [16:0] start_tbl [DOMAIN_DEPTH];
    logic [9:0]  column_tbl[ENTRY_DEPTH];
    logic [15:0] value_tbl [ENTRY_DEPTH];
    logic [10:0] domain_count_r;
    logic [16:0] entry_count_r;
    lookup_result_t expected_scores[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Plain bisection, so an unsorted table yields whatever this probe order finds.
    function automatic logic search_id(input logic [19:0] key, input int unsigned n,
                                       output int unsigned pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo  = 0;
        hi  = n;
        pos = 0;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key < id_tbl[mid]) begin
                hi = mid;
            end else if (key > id_tbl[mid]) begin
                lo = mid + 1;
            end else begin
                pos = mid;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int unsigned clamp_entry(input int unsigned v);
        return (v > ENTRY_DEPTH) ? ENTRY_DEPTH : v;
    endfunction

    function automatic lookup_result_t predict_similarity(input logic [19:0] qa,
                                                          input logic [19:0] qb);
        lookup_result_t res;
        logic [19:0] lo_id;
        logic [19:0] hi_id;
        int unsigned n;
        int unsigned row;
        int unsigned col;
        int unsigned first;
        int unsigned last;
        res.found = 1'b0;
        res.score = SCORE_MISS;
        lo_id = (qa < qb) ? qa : qb;
        hi_id = (qa < qb) ? qb : qa;
        n = (domain_count_r > DOMAIN_DEPTH) ? DOMAIN_DEPTH : domain_count_r;
        if (search_id(lo_id, n, row) && search_id(hi_id, n, col)) begin
            first = clamp_entry(start_tbl[row]);
            last  = clamp_entry((row + 1 != n) ? start_tbl[row + 1] : entry_count_r);
            for (int unsigned k = first; k < last; k++) begin
                if (column_tbl[k] == col[9:0]) begin
                    res.found = 1'b1;
                    res.score = value_tbl[k];
                    break;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        lookup_result_t want;
        lookup_result_t got;
        logic [1:0]  cmd;
        logic [15:0] slot;
        if (!i_rst_n) begin
            domain_count_r = '0;
            entry_count_r  = '0;
            expected_scores.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tuser;
                got.score = m_axis_tdata;
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected result transfer found=%0b score=%0d",
                             $time, got.found, $signed(got.score));
                    o_fail_count++;
                end else begin
                    want = expected_scores.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, got.found);
                        o_fail_count++;
                    end
                    if (got.score !== want.score) begin
                        $display("%0t: score mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.score), $signed(got.score));
                        o_fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DOMAIN_COUNT) begin
                    domain_count_r = cfg_data[10:0];
                end else begin
                    entry_count_r = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cmd  = s_axis_tdata[1:0];
                slot = s_axis_tdata[17:2];
                case (cmd)
                    CMD_LOAD_ID: begin
                        if (slot < DOMAIN_DEPTH) id_tbl[slot] = s_axis_tdata[37:18];
                    end
                    CMD_LOAD_START: begin
                        if (slot < DOMAIN_DEPTH) start_tbl[slot] = s_axis_tdata[54:38];
                    end
                    CMD_LOAD_ENTRY: begin
                        column_tbl[slot] = s_axis_tdata[64:55];
                        value_tbl[slot]  = s_axis_tdata[80:65];
                    end
                    default: begin
                        expected_scores.insert(expected_scores.size(),
                            predict_similarity(s_axis_tdata[100:81], s_axis_tdata[120:101]));
                    end
                endcase
            end
        end
        o_pending = expected_scores.size();
    end
endmodule

>>> bench/sparse_symmetric_matrix_lookup_tb.sv
module sparse_symmetric_matrix_lookup_tb;
    import ssml_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [16:0]  cfg_data;
    int           fail_count;
    int           pending;

    logic [19:0]  loaded_ids[1024];
    int           item_total;
    logic         tx_calm;
    logic         rx_calm;

    sparse_symmetric_matrix_lookup u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ssml_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The result side stalls on its own schedule.
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = rx_calm ? 0 : idle_length();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_command(input logic [1:0] cmd, input logic [15:0] slot,
                                input logic [19:0] id, input logic [16:0] first,
                                input logic [9:0] col, input logic [15:0] val,
                                input logic [19:0] qa, input logic [19:0] qb);
        int gap;
        @(negedge i_clk);
        gap = tx_calm ? 0 : idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {7'd0, qb, qa, val, col, first, id, slot, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        item_total++;
    endtask

    // Unused fields of each command carry random bits.
    task automatic load_id(input int slot, input logic [19:0] id);
        send_command(CMD_LOAD_ID, slot[15:0], id, 17'($urandom), 10'($urandom),
                     16'($urandom), 20'($urandom), 20'($urandom));
    endtask

    task automatic load_start(input int slot, input logic [16:0] first);
        send_command(CMD_LOAD_START, slot[15:0], 20'($urandom), first, 10'($urandom),
                     16'($urandom), 20'($urandom), 20'($urandom));
    endtask

    task automatic load_entry(input int slot, input logic [9:0] col, input logic [15:0] val);
        send_command(CMD_LOAD_ENTRY, slot[15:0], 20'($urandom), 17'($urandom), col, val,
                     20'($urandom), 20'($urandom));
    endtask

    task automatic lookup(input logic [19:0] qa, input logic [19:0] qb);
        send_command(CMD_LOOKUP, 16'($urandom), 20'($urandom), 17'($urandom),
                     10'($urandom), 16'($urandom), qa, qb);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        cfg_index     <= idx;
        cfg_data      <= value;
        cfg_valid     <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Loads a matrix of n identifiers and e entries, then queries it. A large table
    // gets row starts only for its first rows, and its queries stay within them.
    task automatic run_phase(input int n, input int e, input logic [16:0] count_reg,
                             input int queries);
        int unsigned starts[$];
        int unsigned tmp;
        int a;
        int b;
        int rows;
        logic [19:0] qa;
        logic [19:0] qb;
        rows = (n > 64) ? 32 : n;
        drain();
        write_reg(REG_DOMAIN_COUNT, count_reg);
        write_reg(REG_ENTRY_COUNT, 17'(e));
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        loaded_ids[0] = 20'($urandom_range(0, 1000));
        for (int i = 1; i < n; i++) begin
            loaded_ids[i] = loaded_ids[i - 1] + 20'($urandom_range(1, (n > 64) ? 1000 : 15000));
        end
        if ($urandom_range(0, 7) == 0 && n > 1) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            tmp = loaded_ids[a];
            loaded_ids[a] = loaded_ids[b];
            loaded_ids[b] = 20'(tmp);
        end
        if ($urandom_range(0, 7) == 0 && n > 1) begin
            a = $urandom_range(1, n - 1);
            loaded_ids[a] = loaded_ids[a - 1];
        end
        for (int i = 0; i < rows; i++) starts.insert(starts.size(), $urandom_range(0, e));
        starts.sort();
        if ($urandom_range(0, 4) == 0 && rows > 1) begin
            a = $urandom_range(0, rows - 2);
            tmp = starts[a];
            starts[a] = starts[a + 1];
            starts[a + 1] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            load_id(i, loaded_ids[i]);
            if (i < rows) load_start(i, 17'(starts[i]));
            if ($urandom_range(0, 15) == 0) begin
                load_id($urandom_range(1024, 65535), 20'($urandom));
            end
        end
        for (int k = 0; k < e; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                load_entry(k, 10'($urandom), 16'($urandom));
            end else begin
                load_entry(k, 10'($urandom_range(0, n - 1)), 16'($urandom));
            end
        end
        for (int q = 0; q < queries; q++) begin
            if (n > rows) begin
                qa = loaded_ids[$urandom_range(0, rows - 3)];
                qb = loaded_ids[$urandom_range(0, rows - 3)];
            end else begin
                qa = ($urandom_range(0, 4) == 0) ? 20'($urandom)
                                                  : loaded_ids[$urandom_range(0, n - 1)];
                qb = ($urandom_range(0, 4) == 0) ? 20'($urandom)
                                                  : loaded_ids[$urandom_range(0, n - 1)];
            end
            if ($urandom_range(0, 9) == 0) qb = qa;
            lookup(qa, qb);
        end
    endtask

    initial begin
        int n_ids;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_DOMAIN_COUNT;
        cfg_data      = '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        item_total    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // One row reaching the top of the entry store; entry count beyond range.
        write_reg(REG_DOMAIN_COUNT, 17'd1);
        write_reg(REG_ENTRY_COUNT, 17'h1FFFF);
        load_id(0, 20'hFFFFF);
        load_start(0, 17'd65530);
        for (int k = 65530; k < 65535; k++) load_entry(k, 10'd1023, 16'sd32767);
        load_entry(65535, 10'd0, 16'h8000);
        lookup(20'hFFFFF, 20'hFFFFF);
        lookup(20'h00000, 20'hFFFFF);
        // Loads beyond the table depth are dropped.
        load_id(65535, 20'h00000);
        load_start(1024, 17'd0);
        lookup(20'hFFFFF, 20'hFFFFF);
        load_start(0, 17'd65536);
        lookup(20'hFFFFF, 20'hFFFFF);
        load_start(0, 17'h1FFFF);
        lookup(20'hFFFFF, 20'hFFFFF);
        load_id(0, 20'h00000);
        load_start(0, 17'd65534);
        lookup(20'h00000, 20'h00000);
        drain();
        write_reg(REG_DOMAIN_COUNT, 17'd0);
        write_reg(REG_ENTRY_COUNT, 17'd0);
        lookup(20'h00000, 20'h00000);
        lookup(20'hFFFFF, 20'h12345);

        // Full identifier table, with the count register oversized.
        run_phase(1024, 60, 17'd2047, 40);

        while (item_total < 1550) begin
            if ($urandom_range(0, 5) == 0) begin
                n_ids = $urandom_range(13, 48);
                run_phase(n_ids, $urandom_range(0, 100), 17'(n_ids), 20);
            end
            n_ids = $urandom_range(1, 12);
            run_phase(n_ids, $urandom_range(0, 40), 17'(n_ids), 20);
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
